// ===== sv/fcw_pkg.sv =====
// Shared types, codes and a helper function of the FAT12 cluster chain walker.
package fcw_pkg;

  // Input action codes, carried in the slave-side tuser.
  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_START   = 2'd1;
  localparam logic [1:0] ACT_ADVANCE = 2'd2;
  localparam logic [1:0] ACT_UNUSED  = 2'd3;

  // Result status codes, carried in the master-side tuser.
  localparam logic [1:0] ST_DATA = 2'd0;
  localparam logic [1:0] ST_EOC  = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // Cluster number that marks a bad cluster; anything above ends the chain.
  localparam logic [11:0] BAD_CLUSTER = 12'hff7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // take one table byte
    logic start;   // set the walk to the start cluster and report it
    logic report;  // report the current (terminal) cluster again
    logic mod1;    // address reduction, reciprocal product
    logic mod2;    // address reduction, quotient times depth
    logic mod3;    // address reduction, remainder
    logic rd;      // issue the table read
    logic upd;     // take the table entry as the new cluster and report it
  } fcw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic terminal;  // current cluster is bad or end of chain
  } fcw_sts_t;

  // Classify a cluster number.
  function automatic logic [1:0] status_of(input logic [11:0] c);
    logic [1:0] st;
    if (c < BAD_CLUSTER) begin
      st = ST_DATA;
    end else if (c == BAD_CLUSTER) begin
      st = ST_BAD;
    end else begin
      st = ST_EOC;
    end
    return st;
  endfunction

endpackage

// ===== sv/fat12_cluster_chain_walker.sv =====
// Top level of the FAT12 cluster chain walker: stream ports, controller and datapath.
// Table byte beats give no result; a start beat's result is registered at the accepting edge.
// An advance runs through accept, table read and update for a power-of-two TABLE_DEPTH, and
// through accept, three modulo reduction steps, table read and update otherwise, since the
// table read is synchronous and the address must be reduced modulo the depth. An advance from
// a terminal cluster reports at once. Reset clears the walk, unpacking and controller state only; the
// table memory is not cleared and holds undefined data until loaded.
module fat12_cluster_chain_walker import fcw_pkg::*; #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // table_byte [7:0], start_cluster [19:8], zero
  input  logic [1:0]  s_axis_tuser_i,   // action [1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // cluster [11:0], zero
  output logic [1:0]  m_axis_tuser_o    // status [1:0]
);

  fcw_cmd_t    cmd;
  fcw_sts_t    sts;
  logic [11:0] cluster;

  fcw_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .action_i   (s_axis_tuser_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  fcw_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .table_byte_i    (s_axis_tdata_i[7:0]),
    .start_cluster_i (s_axis_tdata_i[19:8]),
    .cluster_o       (cluster),
    .status_o        (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {4'd0, cluster};

endmodule

// ===== sv/fcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fcw_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/fcw_dp.sv =====
// Datapath of the walker: table unpacking, address reduction, table memory, walk register and result register.
module fcw_dp import fcw_pkg::*; #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fcw_cmd_t    cmd_i,
  output fcw_sts_t    sts_o,
  input  logic [7:0]  table_byte_i,
  input  logic [11:0] start_cluster_i,
  output logic [11:0] cluster_o,
  output logic [1:0]  status_o
);

  localparam int AW         = $clog2(TABLE_DEPTH);
  localparam bit DEPTH_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
  // Reciprocal of the depth scaled by 2^24; exact quotients for every 12-bit cluster.
  localparam int RECIP_SH   = 24;
  localparam int RECIP      = ((1 << RECIP_SH) + TABLE_DEPTH - 1) / TABLE_DEPTH;
  localparam logic [20:0] RECIP_C = 21'(RECIP);
  localparam logic [12:0] DEPTH_C = 13'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

  logic [1:0]    phase_q, phase_d;
  logic [7:0]    pend_q, pend_d;
  logic [AW-1:0] widx_q, widx_d;
  logic [11:0]   walk_q, walk_d;
  logic [32:0]   prod_q;
  logic [11:0]   qd_q;
  logic [AW-1:0] addr_q;
  logic [11:0]   out_cluster_q;
  logic [1:0]    out_status_q;

  logic          we;
  logic [11:0]   wdata;
  logic [AW-1:0] raddr;
  logic [11:0]   rdata;
  logic [32:0]   prod_full;
  logic [21:0]   qd_full;
  logic [11:0]   rem_full;

  // Unpacking of byte triples into two 12-bit entries.
  always_comb begin
    phase_d = phase_q;
    pend_d  = pend_q;
    widx_d  = widx_q;
    we      = 1'b0;
    wdata   = {table_byte_i[3:0], pend_q};
    if (cmd_i.load) begin
      case (phase_q)
        2'd1: begin
          we      = 1'b1;
          wdata   = {table_byte_i[3:0], pend_q};
          pend_d  = table_byte_i;
          phase_d = 2'd2;
        end
        2'd2: begin
          we      = 1'b1;
          wdata   = {table_byte_i, pend_q[7:4]};
          pend_d  = 8'd0;
          phase_d = 2'd0;
        end
        default: begin
          pend_d  = table_byte_i;
          phase_d = 2'd1;
        end
      endcase
      if (we) begin
        widx_d = (widx_q == LAST_IDX) ? '0 : widx_q + 1'b1;
      end
    end
  end

  // Walk position follows a start or a table entry.
  always_comb begin
    walk_d = walk_q;
    if (cmd_i.start) begin
      walk_d = start_cluster_i;
    end else if (cmd_i.upd) begin
      walk_d = rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      pend_q  <= 8'd0;
      widx_q  <= '0;
      walk_q  <= 12'd0;
    end else begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
      widx_q  <= widx_d;
      walk_q  <= walk_d;
    end
  end

  // Reduction of the cluster modulo the depth: reciprocal product, back-multiply, subtract.
  assign prod_full = 33'(walk_q) * 33'(RECIP_C);
  assign qd_full   = 22'(prod_q[32:RECIP_SH]) * 22'(DEPTH_C);
  assign rem_full  = walk_q - qd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mod1) begin
      prod_q <= prod_full;
    end
    if (cmd_i.mod2) begin
      qd_q <= qd_full[11:0];
    end
    if (cmd_i.mod3) begin
      addr_q <= rem_full[AW-1:0];
    end
  end

  // A power-of-two depth needs only the low cluster bits.
  assign raddr = DEPTH_POW2 ? walk_q[AW-1:0] : addr_q;

  fcw_ram #(
    .WIDTH (12),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (widx_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      out_cluster_q <= start_cluster_i;
      out_status_q  <= status_of(start_cluster_i);
    end else if (cmd_i.upd) begin
      out_cluster_q <= rdata;
      out_status_q  <= status_of(rdata);
    end else if (cmd_i.report) begin
      out_cluster_q <= walk_q;
      out_status_q  <= status_of(walk_q);
    end
  end

  assign sts_o.terminal = (walk_q >= BAD_CLUSTER);
  assign cluster_o      = out_cluster_q;
  assign status_o       = out_status_q;

endmodule

// ===== sv/fcw_ctrl.sv =====
// Controller of the walker: handshakes, advance sequencing and result valid flag.
module fcw_ctrl import fcw_pkg::*; #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  logic [1:0] action_i,
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output fcw_cmd_t   cmd_o,
  input  fcw_sts_t   sts_i
);

  localparam bit DEPTH_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD1 = 3'd1;
  localparam logic [2:0] S_MOD2 = 3'd2;
  localparam logic [2:0] S_MOD3 = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       acc;
  logic       result_now;

  // The result register is free when empty or being emptied on this edge.
  assign out_free = !out_valid_q || m_tready_i;

  // Loads and ignored codes need no result slot; starts and advances do.
  assign s_tready_o = (state_q == S_IDLE) &&
                      ((action_i == ACT_LOAD) || (action_i == ACT_UNUSED) || out_free);
  assign acc = s_tvalid_i && s_tready_o;

  // Command decode and next state.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (action_i)
            ACT_LOAD:  cmd_o.load  = 1'b1;
            ACT_START: cmd_o.start = 1'b1;
            ACT_ADVANCE: begin
              if (sts_i.terminal) begin
                cmd_o.report = 1'b1;
              end else begin
                state_d = DEPTH_POW2 ? S_RD : S_MOD1;
              end
            end
            default: ;
          endcase
        end
      end
      S_MOD1: begin
        cmd_o.mod1 = 1'b1;
        state_d    = S_MOD2;
      end
      S_MOD2: begin
        cmd_o.mod2 = 1'b1;
        state_d    = S_MOD3;
      end
      S_MOD3: begin
        cmd_o.mod3 = 1'b1;
        state_d    = S_RD;
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result valid flag.
  assign result_now = cmd_o.start || cmd_o.report || cmd_o.upd;
  always_comb begin
    out_valid_d = out_valid_q;
    if (result_now) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_tvalid_o = out_valid_q;

  // A table entry only arrives once the earlier result has left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.upd |-> (!out_valid_q || m_tready_i))
    else $error("table result would overwrite a pending beat");

  // The update cycle always follows the read cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> ($past(state_q) == S_RD))
    else $error("update without a preceding table read");

  // An advance from a terminal cluster is answered on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (action_i == ACT_ADVANCE) && sts_i.terminal) |=>
      (out_valid_q && (state_q == S_IDLE)))
    else $error("terminal advance not reported at once");

  // No beat is taken while an advance is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_tready_o)
    else $error("input taken during an advance");

endmodule

// ===== sim/fcw_walk_checker.sv =====
// Checker for the cluster chain walker: predicts every walk report and compares it on the output.
module fcw_walk_checker import fcw_pkg::*; #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [23:0] s_tdata_i,   // table_byte [7:0], start_cluster [19:8], zero
  input  logic [1:0]  s_tuser_i,   // action [1:0]
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,   // cluster [11:0], zero
  input  logic [1:0]  m_tuser_i,   // status [1:0]
  output int          mismatches_o,
  output int          backlog_o
);

  typedef struct packed {
    logic [11:0] cluster;
    logic [1:0]  status;
  } walk_report_t;

  // Predicted copy of the table and of the unpacking and walk state.
  logic [11:0]  link_tbl [TABLE_DEPTH];
  logic [1:0]   tri_phase = 2'd0;
  logic [7:0]   held_byte = 8'd0;
  int           fill_ptr = 0;
  logic [11:0]  walk_cluster = 12'd0;
  walk_report_t pending_reports [$];
  int           fails = 0;

  // Status of a cluster number: data below the bad mark, bad on it, end of chain above.
  function automatic logic [1:0] grade_cluster(input logic [11:0] c);
    logic [1:0] g;
    if (c < BAD_CLUSTER) begin
      g = ST_DATA;
    end else if (c == BAD_CLUSTER) begin
      g = ST_BAD;
    end else begin
      g = ST_EOC;
    end
    return g;
  endfunction

  // Store one unpacked entry at the fill pointer and move the pointer on, wrapping round.
  task automatic store_link(input logic [11:0] value);
    link_tbl[fill_ptr] = value;
    fill_ptr = (fill_ptr + 1) % TABLE_DEPTH;
  endtask

  // Append the report of the current walk cluster to the expected queue.
  task automatic queue_report();
    walk_report_t r;
    r = '{cluster: walk_cluster, status: grade_cluster(walk_cluster)};
    pending_reports = {pending_reports, r};
  endtask

  // Apply one accepted input beat and queue the report it causes, if any.
  task automatic predict_beat(input logic [1:0] act, input logic [7:0] b,
                              input logic [11:0] c);
    case (act)
      ACT_LOAD: begin
        case (tri_phase)
          2'd0: begin
            held_byte = b;
            tri_phase = 2'd1;
          end
          2'd1: begin
            store_link({b[3:0], held_byte});
            held_byte = b;
            tri_phase = 2'd2;
          end
          default: begin
            store_link({b, held_byte[7:4]});
            held_byte = 8'd0;
            tri_phase = 2'd0;
          end
        endcase
      end
      ACT_START: begin
        walk_cluster = c;
        queue_report();
      end
      ACT_ADVANCE: begin
        // A terminal cluster stays where it is and is reported again.
        if (walk_cluster < BAD_CLUSTER) begin
          walk_cluster = link_tbl[walk_cluster % TABLE_DEPTH];
        end
        queue_report();
      end
      default: begin
      end
    endcase
  endtask

  // Track both channels; input beats are predicted before output beats are compared.
  always @(posedge clk_i or negedge rst_ni) begin : track
    walk_report_t want;
    if (!rst_ni) begin
      tri_phase = 2'd0;
      held_byte = 8'd0;
      fill_ptr = 0;
      walk_cluster = 12'd0;
      pending_reports.delete();
      backlog_o <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        predict_beat(s_tuser_i, s_tdata_i[7:0], s_tdata_i[19:8]);
      end
      if (m_tvalid_i && m_tready_i) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected report: expected none, actual cluster %03h status %0d",
                   $time, m_tdata_i[11:0], m_tuser_i);
          fails++;
        end else begin
          want = pending_reports.pop_front();
          if (m_tdata_i[11:0] !== want.cluster) begin
            $display("%0t: cluster mismatch: expected %03h, actual %03h",
                     $time, want.cluster, m_tdata_i[11:0]);
            fails++;
          end
          if (m_tuser_i !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, m_tuser_i);
            fails++;
          end
        end
      end
      backlog_o <= pending_reports.size();
    end
    mismatches_o <= fails;
  end

endmodule

// ===== sim/tb_fat12_cluster_chain_walker.sv =====
// Testbench top of the cluster chain walker: clock, reset, table and walk stimulus, verdict.
module tb_fat12_cluster_chain_walker import fcw_pkg::*; ();

  localparam int DEPTH       = 4096;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 240;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [23:0] s_data = '0;
  logic [1:0]  s_user = ACT_LOAD;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;
  logic [1:0]  m_user;
  int          mismatches;
  int          outstanding;
  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  bit          hold_req = 1'b0;
  int          cycles = 0;

  // Stimulus-side view of the table, kept so that no advance reads an unwritten entry.
  logic [11:0] shadow_tbl [DEPTH];
  bit          shadow_set [DEPTH];
  logic [1:0]  shadow_phase = 2'd0;
  logic [7:0]  shadow_held = 8'd0;
  int          shadow_ptr = 0;
  int          shadow_hi = 0;
  logic [11:0] shadow_pos = 12'd0;

  fat12_cluster_chain_walker #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user)
  );

  fcw_walk_checker #(
    .TABLE_DEPTH(DEPTH)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tvalid_i  (s_valid),
    .s_tready_i  (s_ready),
    .s_tdata_i   (s_data),
    .s_tuser_i   (s_user),
    .m_tvalid_i  (m_valid),
    .m_tready_i  (m_ready),
    .m_tdata_i   (m_data),
    .m_tuser_i   (m_user),
    .mismatches_o(mismatches),
    .backlog_o   (outstanding)
  );

  // Free-running clock.
  initial begin
    forever #2 clk = ~clk;
  end

  // Cycle counter that ends a run which has hung.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL fat12_cluster_chain_walker");
      $finish;
    end
  end

  // Receiver: random stalls, or one long hold-off when the sender asks for it.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        m_ready <= (int'($urandom_range(99)) >= snk_idle_pct);
      end
    end
  end

  // Offer one beat after a random gap and hold it until it is accepted.
  task automatic send_beat(input logic [1:0] act, input logic [7:0] b, input logic [11:0] c);
    while (int'($urandom_range(99)) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user <= act;
    s_data <= {4'h0, c, b};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
  endtask

  // Send one table byte, noting which entry it completes.
  task automatic put_byte(input logic [7:0] b);
    case (shadow_phase)
      2'd0: begin
        shadow_held = b;
        shadow_phase = 2'd1;
      end
      2'd1: begin
        shadow_tbl[shadow_ptr] = {b[3:0], shadow_held};
        shadow_set[shadow_ptr] = 1'b1;
        if (shadow_ptr > shadow_hi) shadow_hi = shadow_ptr;
        shadow_ptr = (shadow_ptr + 1) % DEPTH;
        shadow_held = b;
        shadow_phase = 2'd2;
      end
      default: begin
        shadow_tbl[shadow_ptr] = {b, shadow_held[7:4]};
        shadow_set[shadow_ptr] = 1'b1;
        if (shadow_ptr > shadow_hi) shadow_hi = shadow_ptr;
        shadow_ptr = (shadow_ptr + 1) % DEPTH;
        shadow_held = 8'd0;
        shadow_phase = 2'd0;
      end
    endcase
    send_beat(ACT_LOAD, b, 12'($urandom));
  endtask

  // Pack two 12-bit entries into their three table bytes.
  task automatic put_pair(input logic [11:0] e0, input logic [11:0] e1);
    put_byte(e0[7:0]);
    put_byte({e1[3:0], e0[11:8]});
    put_byte(e1[11:4]);
  endtask

  task automatic walk_from(input logic [11:0] c);
    shadow_pos = c;
    send_beat(ACT_START, 8'($urandom), c);
  endtask

  task automatic walk_on();
    if (shadow_pos < BAD_CLUSTER) shadow_pos = shadow_tbl[shadow_pos % DEPTH];
    send_beat(ACT_ADVANCE, 8'($urandom), 12'($urandom));
  endtask

  // An advance is allowed from a terminal cluster or where the entry has been written.
  function automatic bit advance_ok();
    return (shadow_pos >= BAD_CLUSTER) || shadow_set[shadow_pos % DEPTH];
  endfunction

  // Cluster near the written part of the table, so that walks run deep.
  function automatic logic [11:0] near_cluster();
    int bound;
    bound = (shadow_hi + 3 < DEPTH) ? shadow_hi + 3 : DEPTH - 1;
    return 12'($urandom_range(bound));
  endfunction

  function automatic logic [11:0] terminal_cluster();
    logic [11:0] c;
    if ($urandom_range(1) == 0) begin
      c = BAD_CLUSTER;
    end else begin
      c = 12'($urandom_range(12'hfff, 12'hff8));
    end
    return c;
  endfunction

  // Table entry: mostly a link into the table, some terminal marks, a few arbitrary values.
  function automatic logic [11:0] pick_link();
    int r;
    logic [11:0] c;
    r = $urandom_range(99);
    if (r < 70) begin
      c = near_cluster();
    end else if (r < 85) begin
      c = terminal_cluster();
    end else begin
      c = 12'($urandom);
    end
    return c;
  endfunction

  function automatic logic [11:0] pick_start();
    int r;
    logic [11:0] c;
    r = $urandom_range(99);
    if (r < 75) begin
      c = near_cluster();
    end else if (r < 90) begin
      c = terminal_cluster();
    end else begin
      c = 12'($urandom);
    end
    return c;
  endfunction

  // One random step: well-formed byte triples and walks, with stray bytes and unused codes.
  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 30) begin
      put_pair(pick_link(), pick_link());
    end else if (r < 35) begin
      put_byte(8'($urandom));
    end else if (r < 47) begin
      walk_from(pick_start());
    end else if (r < 95) begin
      if (advance_ok()) begin
        walk_on();
      end else begin
        walk_from(pick_start());
      end
    end else begin
      send_beat(ACT_UNUSED, 8'($urandom), 12'($urandom));
    end
  endtask

  // Main sequence: reset, directed cases, three idling phases, then drain and verdict.
  initial begin
    int waited;
    waited = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct = 29;
    snk_idle_pct = 82;

    // Entries 0..5 are 002, bad, 003, end, ff8, 000.
    put_pair(12'h002, BAD_CLUSTER);
    put_pair(12'h003, 12'hfff);
    put_pair(12'hff8, 12'h000);
    // Advancing before any start walks from cluster 0 to the end and repeats it.
    walk_on();
    walk_on();
    walk_on();
    walk_on();
    // Reserved cluster 1 is data; its link is bad, which then repeats.
    walk_from(12'h001);
    walk_on();
    walk_on();
    // Starts on the status boundaries.
    walk_from(BAD_CLUSTER);
    walk_from(12'hfff);
    walk_on();
    walk_from(12'hff8);
    walk_from(12'hff6);
    walk_from(12'h004);
    walk_on();
    walk_from(12'h005);
    walk_on();
    walk_on();
    // The unused action code is ignored.
    send_beat(ACT_UNUSED, 8'hff, 12'hfff);

    repeat (PHASE_ITEMS) random_item();

    src_idle_pct = 82;
    snk_idle_pct = 29;
    repeat (PHASE_ITEMS) random_item();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    // The receiver holds off while walks keep coming, so the input backs up.
    hold_req = 1'b1;
    repeat (PHASE_ITEMS) random_item();

    s_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (outstanding != 0) begin
      $display("FAIL fat12_cluster_chain_walker");
      $finish;
    end else begin
      repeat (10) @(posedge clk);
      if (mismatches == 0 && outstanding == 0) begin
        $display("PASS fat12_cluster_chain_walker");
      end else begin
        $display("FAIL fat12_cluster_chain_walker");
      end
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
sv/fcw_pkg.sv
sv/fcw_ram.sv
sv/fcw_dp.sv
sv/fcw_ctrl.sv
sv/fat12_cluster_chain_walker.sv
sim/fcw_walk_checker.sv
sim/tb_fat12_cluster_chain_walker.sv
